// File: rtl/lcts_pkg.sv
// lcts_pkg: shared constants for the load cell tare and scale unit.
// No dependencies; imported by every module of the unit.
`default_nettype none
package lcts_pkg;

	localparam int SAMPLE_W      = 24;
	localparam int DIVISOR_W     = 24;
	localparam int REF_W         = 25;
	localparam int MASS_W        = 16;
	localparam int WEIGHT_W      = 26;
	localparam int SCALE_W       = 25;
	localparam int AVG_COUNT_DEF = 5;
	localparam int CFG_IDX_W     = 1;

	localparam logic [SAMPLE_W-1:0] SIGN_FLIP = 24'h800000;

	// input actions (carried in s_tuser)
	localparam logic [1:0] ACT_WEIGH = 2'd0;
	localparam logic [1:0] ACT_TARE  = 2'd1;
	localparam logic [1:0] ACT_CAL   = 2'd2;

	// result kinds (carried in m_tuser)
	localparam logic [1:0] KIND_WEIGHT = 2'd0;
	localparam logic [1:0] KIND_TARE   = 2'd1;
	localparam logic [1:0] KIND_CAL    = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_REF_WEIGHT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STD_MASS   = 1'd1;

endpackage
`default_nettype wire

// File: rtl/lcts_serial_div.sv
// lcts_serial_div: unsigned restoring divider, one quotient bit per cycle.
// Uses lcts_pkg for the divisor width.
`default_nettype none
module lcts_serial_div
	import lcts_pkg::*;
#(
	parameter int DW = 27
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [DW-1:0]        dividend,
	input  wire logic [DIVISOR_W-1:0] divisor,
	output logic                      done,
	output logic [DW-1:0]             quotient
);

	localparam int CNT_W = $clog2(DW);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DW - 1);

	logic [DIVISOR_W:0]   rem_q;
	logic [DW-1:0]        quo_q;
	logic [DIVISOR_W-1:0] dvs_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIVISOR_W:0]   rem_sh;
	logic [DIVISOR_W+1:0] diff;
	logic                 qbit;

	// shift the next dividend bit into the partial remainder, trial subtract
	assign rem_sh = {rem_q[DIVISOR_W-1:0], quo_q[DW-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
	assign qbit   = ~diff[DIVISOR_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= '0;
				quo_q  <= dividend;
				dvs_q  <= divisor;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= qbit ? diff[DIVISOR_W:0] : rem_sh;
				quo_q <= {quo_q[DW-2:0], qbit};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider started while busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while still busy");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q < {1'b0, dvs_q})) else $error("partial remainder out of range");

endmodule
`default_nettype wire

// File: rtl/load_cell_tare_scale_unit_top.sv
// load_cell_tare_scale_unit_top: tare, calibrate and weigh; uses lcts_pkg, lcts_serial_div.
// Weigh, the last tare sample and every calibration sample go through the DW-bit serial divider
// (DW = 24 + clog2(AVERAGE_COUNT), 27 by default); the last calibration sample divides twice.
// Other run samples give no result. One item at a time: s_tready is high only while idle, so
// a divide, the result hand-off and a held output all keep the next item out.
// arst_n clears offset to 0, scale to 1, run state, config to 0 and 1, and the output.
`default_nettype none
module load_cell_tare_scale_unit_top
	import lcts_pkg::*;
#(
	parameter int AVERAGE_COUNT = AVG_COUNT_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// input stream
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [23:0]          s_tdata,   // [23:0] raw_word
	input  wire logic [1:0]           s_tuser,   // [1:0] action
	// result stream
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [31:0]               m_tdata,   // [25:0] weight_value, [31:26] zero
	output logic [2:0]                m_tuser,   // [1:0] result_kind, [2] scale_fault
	// register writes
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [REF_W-1:0]     cfg_data
);

	// run counter and sum widths follow from the averaging count
	localparam int CW    = $clog2(AVERAGE_COUNT);
	localparam int CNT_W = (AVERAGE_COUNT > 1) ? CW : 1;
	localparam int DW    = SAMPLE_W + CW;   // magnitude of any dividend
	localparam int SUM_W = DW + 1;          // signed running sum
	localparam logic [CNT_W-1:0]     LAST_CNT = CNT_W'(AVERAGE_COUNT - 1);
	localparam logic [DIVISOR_W-1:0] AVG_DIV  = DIVISOR_W'(AVERAGE_COUNT);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV1,   // delta / scale (weigh) or delta / mass (calibrate)
		ST_DIV2,   // run sum / AVERAGE_COUNT
		ST_EMIT    // wait for the output register
	} state_t;

	typedef enum logic [1:0] {
		PH_WEIGH,
		PH_TARE,
		PH_CAL
	} phase_t;

	state_t state_q;
	phase_t phase_q;

	// configuration
	logic signed [REF_W-1:0] ref_weight_q;
	logic [MASS_W-1:0]       std_mass_q;

	// calibration state
	logic [SAMPLE_W-1:0]       zero_offset_q;
	logic signed [SCALE_W-1:0] cpg_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [1:0]                act_q;

	// divider operands
	logic                 div_start_q;
	logic [DW-1:0]        div_dvd_q;
	logic [DIVISOR_W-1:0] div_dvs_q;
	logic                 div_neg_q;
	logic                 div_done;
	logic [DW-1:0]        div_quo;

	// pending result and output register
	logic [1:0]            res_kind_q;
	logic [WEIGHT_W-1:0]   res_value_q;
	logic                  res_fault_q;
	logic                  out_valid_q;
	logic [1:0]            out_kind_q;
	logic [WEIGHT_W-1:0]   out_value_q;
	logic                  out_fault_q;

	// combinational helpers
	logic [SAMPLE_W-1:0]     sample_c;
	logic                    item_ok_c;
	logic                    in_xfer;
	logic signed [SAMPLE_W:0] delta_c;
	logic [SAMPLE_W:0]       delta_neg_c;
	logic [DIVISOR_W-1:0]    delta_mag_c;
	logic [SCALE_W-1:0]      cpg_neg_c;
	logic [DIVISOR_W-1:0]    cpg_mag_c;
	logic [DIVISOR_W-1:0]    mass_eff_c;
	logic signed [SUM_W-1:0] tare_base_c;
	logic [CNT_W-1:0]        tare_cnt_c;
	logic signed [SUM_W-1:0] tare_sum_c;
	logic signed [SUM_W-1:0] q_signed_c;
	logic signed [SUM_W-1:0] cal_sum_c;
	logic [SUM_W-1:0]        cal_neg_c;
	logic [DW-1:0]           cal_mag_c;
	logic [WEIGHT_W-1:0]     weight_c;
	logic [SCALE_W-1:0]      avg_c;

	// flip to offset binary; an all-zero sample is a failed read and is dropped,
	// as is the unused action code
	assign sample_c  = s_tdata ^ SIGN_FLIP;
	assign item_ok_c = (s_tuser == ACT_WEIGH || s_tuser == ACT_TARE || s_tuser == ACT_CAL)
		&& (sample_c != '0);
	assign in_xfer   = s_tvalid && s_tready;

	assign delta_c     = $signed({1'b0, sample_c}) - $signed({1'b0, zero_offset_q});
	assign delta_neg_c = -delta_c;
	assign delta_mag_c = delta_c[SAMPLE_W] ? delta_neg_c[DIVISOR_W-1:0]
		: delta_c[DIVISOR_W-1:0];
	assign cpg_neg_c   = -cpg_q;
	assign cpg_mag_c   = cpg_q[SCALE_W-1] ? cpg_neg_c[DIVISOR_W-1:0] : cpg_q[DIVISOR_W-1:0];
	assign mass_eff_c  = (std_mass_q == '0) ? DIVISOR_W'(1)
		: {{(DIVISOR_W-MASS_W){1'b0}}, std_mass_q};

	// a tare sample outside a tare run starts a new one
	assign tare_base_c = (phase_q == PH_TARE) ? sum_q : '0;
	assign tare_cnt_c  = (phase_q == PH_TARE) ? cnt_q : '0;
	assign tare_sum_c  = tare_base_c + $signed({{(SUM_W-SAMPLE_W){1'b0}}, sample_c});

	// truncating signed division: divide magnitudes, then restore the sign
	assign q_signed_c = div_neg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
	assign cal_sum_c  = sum_q + q_signed_c;
	assign cal_neg_c  = -cal_sum_c;
	assign cal_mag_c  = cal_sum_c[SUM_W-1] ? cal_neg_c[DW-1:0] : cal_sum_c[DW-1:0];

	assign weight_c = {q_signed_c[SCALE_W-1], q_signed_c[SCALE_W-1:0]}
		- {ref_weight_q[REF_W-1], ref_weight_q};
	assign avg_c    = q_signed_c[SCALE_W-1:0];

	lcts_serial_div #(
		.DW(DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_dvd_q),
		.divisor  (div_dvs_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// register writes are always taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_weight_q <= '0;
			std_mass_q   <= MASS_W'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_REF_WEIGHT: ref_weight_q <= cfg_data;
				CFG_STD_MASS:   std_mass_q   <= cfg_data[MASS_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer, run state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			phase_q       <= PH_WEIGH;
			zero_offset_q <= '0;
			cpg_q         <= SCALE_W'(1);
			sum_q         <= '0;
			cnt_q         <= '0;
			act_q         <= ACT_WEIGH;
			div_start_q   <= 1'b0;
			div_dvd_q     <= '0;
			div_dvs_q     <= '0;
			div_neg_q     <= 1'b0;
			res_kind_q    <= KIND_WEIGHT;
			res_value_q   <= '0;
			res_fault_q   <= 1'b0;
			out_valid_q   <= 1'b0;
			out_kind_q    <= KIND_WEIGHT;
			out_value_q   <= '0;
			out_fault_q   <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			// in ST_EMIT the output register is reloaded below instead
			if (m_tready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer && item_ok_c) begin
						act_q <= s_tuser;
						case (s_tuser)
							ACT_WEIGH: begin
								// weighing abandons any run in progress
								phase_q     <= PH_WEIGH;
								sum_q       <= '0;
								cnt_q       <= '0;
								div_dvd_q   <= DW'(delta_mag_c);
								div_dvs_q   <= cpg_mag_c;
								div_neg_q   <= delta_c[SAMPLE_W] ^ cpg_q[SCALE_W-1];
								div_start_q <= 1'b1;
								state_q     <= ST_DIV1;
							end
							ACT_TARE: begin
								phase_q <= PH_TARE;
								cpg_q   <= SCALE_W'(1);
								sum_q   <= tare_sum_c;
								if (tare_cnt_c == LAST_CNT) begin
									div_dvd_q   <= tare_sum_c[DW-1:0];
									div_dvs_q   <= AVG_DIV;
									div_neg_q   <= 1'b0;
									div_start_q <= 1'b1;
									state_q     <= ST_DIV2;
								end else begin
									cnt_q <= tare_cnt_c + 1'b1;
								end
							end
							ACT_CAL: begin
								if (phase_q != PH_CAL) begin
									sum_q <= '0;
									cnt_q <= '0;
								end
								phase_q     <= PH_CAL;
								div_dvd_q   <= DW'(delta_mag_c);
								div_dvs_q   <= mass_eff_c;
								div_neg_q   <= delta_c[SAMPLE_W];
								div_start_q <= 1'b1;
								state_q     <= ST_DIV1;
							end
							default: ;
						endcase
					end
				end
				ST_DIV1: begin
					if (div_done) begin
						if (act_q == ACT_WEIGH) begin
							res_kind_q  <= KIND_WEIGHT;
							res_value_q <= weight_c;
							res_fault_q <= 1'b0;
							state_q     <= ST_EMIT;
						end else begin
							sum_q <= cal_sum_c;
							if (cnt_q == LAST_CNT) begin
								div_dvd_q   <= cal_mag_c;
								div_dvs_q   <= AVG_DIV;
								div_neg_q   <= cal_sum_c[SUM_W-1];
								div_start_q <= 1'b1;
								state_q     <= ST_DIV2;
							end else begin
								cnt_q   <= cnt_q + 1'b1;
								state_q <= ST_IDLE;
							end
						end
					end
				end
				ST_DIV2: begin
					if (div_done) begin
						// run complete
						sum_q   <= '0;
						cnt_q   <= '0;
						phase_q <= PH_WEIGH;
						state_q <= ST_EMIT;
						if (act_q == ACT_TARE) begin
							zero_offset_q <= div_quo[SAMPLE_W-1:0];
							res_kind_q    <= KIND_TARE;
							res_value_q   <= {{(WEIGHT_W-SAMPLE_W){1'b0}},
								div_quo[SAMPLE_W-1:0]};
							res_fault_q   <= 1'b0;
						end else begin
							res_kind_q <= KIND_CAL;
							if (avg_c == '0) begin
								// zero scale is replaced by 1 and flagged
								cpg_q       <= SCALE_W'(1);
								res_value_q <= WEIGHT_W'(1);
								res_fault_q <= 1'b1;
							end else begin
								cpg_q       <= avg_c;
								res_value_q <= {avg_c[SCALE_W-1], avg_c};
								res_fault_q <= 1'b0;
							end
						end
					end
				end
				ST_EMIT: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= res_kind_q;
						out_value_q <= res_value_q;
						out_fault_q <= res_fault_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {{(32-WEIGHT_W){1'b0}}, out_value_q};
	assign m_tuser   = {out_fault_q, out_kind_q};

	a_scale_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cpg_q != '0) else $error("scale register reached zero");
	a_weigh_phase_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_WEIGH) |-> (sum_q == '0 && cnt_q == '0))
		else $error("run state left over outside a run");
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV1 || state_q == ST_DIV2))
		else $error("divider finished outside a divide state");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= LAST_CNT) else $error("run counter past averaging count");

endmodule
`default_nettype wire

// File: bench/tb_load_cell_tare_scale_unit_top.sv
// Self-checking bench for load_cell_tare_scale_unit_top: a queue-fed driver and a monitor
// that checks each result against a cycle-free prediction of offset, scale and weight.
// Depends on rtl/lcts_pkg.sv and the unit's RTL.
`timescale 1ns / 1ps

module tb_load_cell_tare_scale_unit_top;
	import lcts_pkg::*;

	localparam int          RUN_LEN     = AVG_COUNT_DEF;
	localparam logic [1:0]  ACT_NONE    = 2'd3;   // unused action code, ignored by the unit
	localparam int          MAX_GAP     = 17;
	localparam int          LONG_HOLD   = 400;    // receiver hold-off, forces input backpressure
	localparam int          DRAIN_WAIT  = 100;    // covers the longest calibration latency
	localparam int          STALL_LIMIT = 3000;   // cycles without any transfer
	localparam int          PHASES      = 6;
	localparam int          PHASE_ITEMS = 70;

	typedef enum logic [1:0] {RUN_NONE, RUN_TARE, RUN_CAL} run_kind_t;

	typedef struct {
		logic [1:0]  action;
		logic [23:0] raw;
	} load_item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [25:0] grams;
		logic               fault;
	} reading_t;

	// clock and DUT ports; every input known from time zero
	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [23:0]          s_tdata   = '0;    // [23:0] raw_word
	logic [1:0]           s_tuser   = '0;    // [1:0] action
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [31:0]          m_tdata;           // [25:0] weight_value, [31:26] zero
	logic [2:0]           m_tuser;           // [1:0] result_kind, [2] scale_fault
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [REF_W-1:0]     cfg_data  = '0;

	load_item_t sample_queue[$];        // items waiting for the driver
	reading_t   expected_readings[$];   // predicted results, oldest first
	int         fail_count    = 0;
	logic       no_idle       = 1'b0;   // both sides run without gaps while set
	int         hold_requests = 0;      // bumped by the sequencer, served by the receiver
	int         holds_served  = 0;

	// handshake history, seen by the negedge drivers
	logic s_took = 1'b0;
	logic m_took = 1'b0;
	int   send_gap = 0;
	int   recv_wait = 0;

	// predicted unit state and register copies
	logic [23:0]        tare_offset;
	logic signed [24:0] scale_counts;
	logic signed [28:0] run_sum;
	logic [3:0]         run_count;
	run_kind_t          run_kind;
	logic signed [24:0] ref_weight_cfg;
	logic [15:0]        std_mass_cfg;

	// generator side: last tare level and mass in force, used to shape calibration runs
	longint gen_base = 0;
	longint gen_mass = 1;

	load_cell_tare_scale_unit_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------------------------
	// Prediction: one accepted item moves the tare/calibration run and may yield a result.
	// Samples are offset binary (bit 23 flipped); a zero sample is a failed read.
	// ---------------------------------------------------------------------------------
	task automatic apply_sample(input logic [1:0] action, input logic [23:0] raw);
		logic [23:0] sample;
		longint      delta;
		longint      mass;
		longint      avg;
		reading_t    r;
		sample = raw ^ SIGN_FLIP;
		if (action == ACT_NONE || sample == '0)
			return;
		delta = longint'(sample) - longint'(tare_offset);
		r.fault = 1'b0;
		case (action)
			ACT_WEIGH: begin
				// any weighing abandons a run in progress
				run_kind  = RUN_NONE;
				run_sum   = '0;
				run_count = '0;
				avg = delta / (scale_counts != 0 ? longint'(scale_counts) : 64'sd1);
				avg = avg - longint'(ref_weight_cfg);
				r.kind  = KIND_WEIGHT;
				r.grams = avg[25:0];
				expected_readings.push_back(r);
			end
			ACT_TARE: begin
				if (run_kind != RUN_TARE) begin
					run_kind     = RUN_TARE;
					run_sum      = '0;
					run_count    = '0;
					scale_counts = 25'sd1;   // a new tare drops the old calibration
				end
				run_sum   = run_sum + 29'(sample);
				run_count = run_count + 1'b1;
				if (run_count >= RUN_LEN) begin
					avg = longint'(run_sum) / RUN_LEN;
					tare_offset = avg[23:0];
					run_kind  = RUN_NONE;
					run_sum   = '0;
					run_count = '0;
					r.kind  = KIND_TARE;
					r.grams = {2'b00, tare_offset};
					expected_readings.push_back(r);
				end
			end
			default: begin
				mass = (std_mass_cfg != '0) ? longint'(std_mass_cfg) : 64'sd1;
				if (run_kind != RUN_CAL) begin
					run_kind  = RUN_CAL;
					run_sum   = '0;
					run_count = '0;
				end
				avg       = delta / mass;
				run_sum   = run_sum + avg[28:0];
				run_count = run_count + 1'b1;
				if (run_count >= RUN_LEN) begin
					avg = longint'(run_sum) / RUN_LEN;
					if (avg == 0) begin
						// zero scale would divide by zero later: substitute one and flag it
						avg     = 1;
						r.fault = 1'b1;
					end
					scale_counts = avg[24:0];
					run_kind  = RUN_NONE;
					run_sum   = '0;
					run_count = '0;
					r.kind  = KIND_CAL;
					r.grams = avg[25:0];
					expected_readings.push_back(r);
				end
			end
		endcase
	endtask

	// monitor and predictor; results are checked before a same-edge input is predicted
	always @(posedge clk or negedge arst_n) begin
		reading_t want;
		if (!arst_n) begin
			tare_offset    = '0;
			scale_counts   = 25'sd1;
			run_sum        = '0;
			run_count      = '0;
			run_kind       = RUN_NONE;
			ref_weight_cfg = '0;
			std_mass_cfg   = 16'd1;
			s_took <= 1'b0;
			m_took <= 1'b0;
		end else begin
			s_took <= s_tvalid && s_tready;
			m_took <= m_tvalid && m_tready;
			if (m_tvalid && m_tready) begin
				if (expected_readings.size() == 0) begin
					$error("unexpected result: kind %0d weight_value %0d fault %0d",
						m_tuser[1:0], $signed(m_tdata[25:0]), m_tuser[2]);
					fail_count++;
				end else begin
					want = expected_readings.pop_front();
					if (m_tuser[1:0] != want.kind) begin
						$error("result_kind: expected %0d, actual %0d", want.kind, m_tuser[1:0]);
						fail_count++;
					end
					if (m_tdata[25:0] != want.grams) begin
						$error("weight_value: expected %0d, actual %0d",
							want.grams, $signed(m_tdata[25:0]));
						fail_count++;
					end
					if (m_tuser[2] != want.fault) begin
						$error("scale_fault: expected %0d, actual %0d", want.fault, m_tuser[2]);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_REF_WEIGHT: ref_weight_cfg = cfg_data;
					CFG_STD_MASS:   std_mass_cfg   = cfg_data[15:0];
					default:        ;
				endcase
			end
			if (s_tvalid && s_tready)
				apply_sample(s_tuser, s_tdata);
		end
	end

	// input driver: holds an item until its transfer, then idles a random gap
	always @(negedge clk) begin
		load_item_t item;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_gap <= 0;
		end else if (!s_tvalid || s_took) begin
			if (send_gap != 0) begin
				s_tvalid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (sample_queue.size() != 0) begin
				item = sample_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= item.raw;
				s_tuser  <= item.action;
				send_gap <= no_idle ? 0 : $urandom_range(0, MAX_GAP);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result receiver: random stall after each transfer, long hold-off on request
	always @(negedge clk) begin
		int w;
		if (!arst_n) begin
			m_tready  <= 1'b0;
			recv_wait <= 0;
		end else if (holds_served != hold_requests) begin
			holds_served <= holds_served + 1;
			recv_wait    <= LONG_HOLD;
			m_tready     <= 1'b0;
		end else if (m_took) begin
			w = no_idle ? 0 : $urandom_range(0, MAX_GAP);
			recv_wait <= w;
			m_tready  <= (w == 0);
		end else if (recv_wait != 0) begin
			recv_wait <= recv_wait - 1;
			m_tready  <= (recv_wait == 1);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// watchdog: any transfer on any channel restarts the count
	always @(posedge clk) begin
		int quiet;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= STALL_LIMIT) begin
			$display("tb_load_cell_tare_scale_unit_top: errors");
			$finish;
		end
	end

	// ---------------------------------------------------------------------------------
	// Stimulus helpers, all in the offset-binary sample domain
	// ---------------------------------------------------------------------------------
	function automatic void queue_sample(input logic [1:0] action, input longint sample);
		load_item_t item;
		logic [23:0] s;
		s = sample[23:0];
		item.action = action;
		item.raw    = s ^ SIGN_FLIP;
		sample_queue.push_back(item);
	endfunction

	// len samples of one action scattered by up to +/- spread around center
	function automatic void queue_run(input logic [1:0] action, input longint center,
		input int spread, input int len);
		for (int i = 0; i < len; i++)
			queue_sample(action, center + longint'($urandom_range(0, 2 * spread)) - spread);
	endfunction

	// wait until the unit has nothing left to deliver, then out its longest latency
	task automatic wait_drained();
		while (sample_queue.size() != 0 || s_tvalid || expected_readings.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [REF_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// random traffic: mostly whole tare and calibration runs, some broken runs and noise
	task automatic queue_random(input int count);
		int     pick;
		int     len;
		longint k;
		int     start;
		start = sample_queue.size();
		while (sample_queue.size() - start < count) begin
			pick = $urandom_range(0, 99);
			// about one run in six is cut short and abandoned by whatever follows
			len  = ($urandom_range(0, 5) == 0) ? $urandom_range(1, RUN_LEN - 1) : RUN_LEN;
			if (pick < 35) begin
				if ($urandom_range(0, 1))
					queue_sample(ACT_WEIGH, gen_base + longint'($urandom_range(0, 2097152)) - 1048576);
				else
					queue_sample(ACT_WEIGH, longint'($urandom()));
			end else if (pick < 55) begin
				gen_base = longint'($urandom_range(1, 24'hFFFFFF));
				queue_run(ACT_TARE, gen_base, $urandom_range(0, 64), len);
			end else if (pick < 78) begin
				k = longint'($urandom_range(0, int'(8000000 / gen_mass)));
				if ($urandom_range(0, 1))
					k = -k;
				queue_run(ACT_CAL, gen_base + k * gen_mass,
					int'(longint'($urandom_range(0, 3)) * gen_mass), len);
			end else if (pick < 88) begin
				// failed read under any action, or an unused action with any word
				if ($urandom_range(0, 1))
					queue_sample(2'($urandom_range(0, 3)), 0);
				else
					queue_sample(ACT_NONE, longint'($urandom()));
			end else begin
				queue_sample(2'($urandom_range(0, 3)), longint'($urandom()));
			end
		end
	endtask

	// ---------------------------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------------------------
	initial begin
		int     ref_set  [PHASES];
		int     mass_set [PHASES];
		logic [8:0] junk;

		// phase 0 runs on reset values; the rest cover both register extremes
		ref_set  = '{0, 16777215, -16777215, 0, 0, 0};
		mass_set = '{1, 65535, 1, 0, 0, 37};
		ref_set[4]  = int'($urandom_range(0, 33554430)) - 16777215;
		mass_set[4] = $urandom_range(1, 65535);
		ref_set[5]  = int'($urandom_range(0, 2000)) - 1000;

		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// directed: word extremes, failed read, unused action
		queue_sample(ACT_WEIGH, 24'hFFFFFF);
		queue_sample(ACT_WEIGH, 1);
		queue_sample(ACT_WEIGH, 24'h800000);
		queue_sample(ACT_WEIGH, 0);
		queue_sample(ACT_NONE, 24'h7FFFFF);
		// flat tare, then calibration on the same level: zero scale, fault raised
		queue_run(ACT_TARE, 24'h400000, 0, RUN_LEN);
		queue_run(ACT_CAL, 24'h400000, 0, RUN_LEN);
		// partial tare resets scale to one, calibration sample switches run, weigh abandons
		queue_run(ACT_TARE, 24'h123456, 0, 2);
		queue_sample(ACT_TARE, 0);
		queue_sample(ACT_CAL, 24'h500000);
		queue_sample(ACT_WEIGH, 24'h400100);
		// clean calibration to 1000 counts per gram, then a weighing on it
		queue_run(ACT_CAL, 24'h400000 + 1000, 0, RUN_LEN);
		queue_sample(ACT_WEIGH, 24'h400000 + 50000);
		gen_base = 24'h400000;
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			if (p != 0) begin
				junk = 9'($urandom());
				write_register(CFG_REF_WEIGHT, 25'(ref_set[p]));
				// upper bits of the mass write are don't-care: drive them random
				write_register(CFG_STD_MASS, {junk[8:0], 16'(mass_set[p])});
			end
			gen_mass = (mass_set[p] == 0) ? 1 : mass_set[p];
			no_idle  = (p == 3);
			queue_random(PHASE_ITEMS);
			// stall results for a long stretch while items keep coming
			if (p == 2)
				hold_requests++;
			wait_drained();
		end

		if (fail_count == 0 && expected_readings.size() == 0)
			$display("tb_load_cell_tare_scale_unit_top: clean");
		else
			$display("tb_load_cell_tare_scale_unit_top: errors");
		$finish;
	end

endmodule
